>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/rbd_pkg.sv
// Shared types and codes for the ring buffer deque.
`default_nettype none

package rbd_pkg;

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic capture;
    logic scan;
    logic load;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_rd;
    logic need_scan;
    logic scan_hit;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

>>> design/ring_buffer_deque.sv
// Top level of the ring buffer deque: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_cmd, in_data_in, in_position
//  out     | output    | out_valid / out_ready| out_status, out_data_out,
//          |           |                      | out_found_position, out_occupancy
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (capacity in use)
//
// Push, reserved codes and full, empty or range errors step through accept, execute and
// load, and the result is registered at load. Pop and read at add a step for the
// registered store read. Find reads one entry a cycle until a match or the last entry;
// the single store read port sets the rate.
// A request is taken while the last result waits; a stalled result holds the next.
// Reset empties the deque and sets capacity to min(16, DEPTH); a capacity write empties it.
`default_nettype none

module ring_buffer_deque #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rbd_pkg::CMD_W-1:0]   in_cmd,
  input  logic [rbd_pkg::DATA_W-1:0]  in_data_in,
  input  logic [rbd_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rbd_pkg::STAT_W-1:0]  out_status,
  output logic [rbd_pkg::DATA_W-1:0]  out_data_out,
  output logic [rbd_pkg::POS_W-1:0]   out_found_position,
  output logic [rbd_pkg::CNT_W-1:0]   out_occupancy,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rbd_pkg::CNT_W-1:0]   cfg_data
);

  rbd_pkg::ctl_t ctl;
  rbd_pkg::sts_t sts;

  // Take capacity writes only while idle and no request is offered
  assign cfg_ready = in_ready && !in_valid;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rbd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_data_in         (in_data_in),
    .in_position        (in_position),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_status         (out_status),
    .out_data_out       (out_data_out),
    .out_found_position (out_found_position),
    .out_occupancy      (out_occupancy)
  );

endmodule

`default_nettype wire

>>> design/rbd_ctrl.sv
// Controller state machine for the ring buffer deque.
`default_nettype none

module rbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rbd_pkg::sts_t sts,
  output rbd_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_FIND,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Decode commands from the current state
  always_comb begin
    ctl.accept  = (state_r == S_IDLE) && in_valid;
    ctl.exec    = (state_r == S_EXEC);
    ctl.capture = (state_r == S_RDATA);
    ctl.scan    = (state_r == S_FIND);
    ctl.load    = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  end

  // Next state and result valid
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.need_rd) state_nxt = S_RDATA;
        else if (sts.need_scan)   state_nxt = S_FIND;
        else                      state_nxt = S_RESULT;
      end
      S_RDATA: begin
        state_nxt = S_RESULT;
      end
      S_FIND: begin
        if (sts.scan_hit || sts.scan_last) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (ctl.load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    priority if (ctl.load) out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> design/rbd_dp.sv
// Datapath for the ring buffer deque: ring store, pointers, scan and result registers.
`default_nettype none

module rbd_dp #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rbd_pkg::ctl_t               ctl,
  output rbd_pkg::sts_t               sts,
  input  logic [rbd_pkg::CMD_W-1:0]   in_cmd,
  input  logic [rbd_pkg::DATA_W-1:0]  in_data_in,
  input  logic [rbd_pkg::POS_W-1:0]   in_position,
  input  logic                        cfg_we,
  input  logic [rbd_pkg::CNT_W-1:0]   cfg_data,
  output logic [rbd_pkg::STAT_W-1:0]  out_status,
  output logic [rbd_pkg::DATA_W-1:0]  out_data_out,
  output logic [rbd_pkg::POS_W-1:0]   out_found_position,
  output logic [rbd_pkg::CNT_W-1:0]   out_occupancy
);

  localparam int CW      = rbd_pkg::CNT_W;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW      = (AW < CW) ? AW : CW;
  localparam int CAP_LIM = (1 << CW) - 1;
  localparam int CAP_MAX = (DEPTH < CAP_LIM) ? DEPTH : CAP_LIM;
  localparam int CAP_RST = (CAP_MAX < 16) ? CAP_MAX : 16;
  localparam logic [CW-1:0] CAP_MAX_V = CW'(CAP_MAX);
  localparam logic [CW-1:0] CAP_RST_V = CW'(CAP_RST);

  // Slot plus offset, wrapped once against the capacity
  function automatic logic [CW:0] wrap_add(input logic [CW:0] a, input logic [CW:0] b,
                                           input logic [CW:0] cap);
    logic [CW:0] s;
    s = a + b;
    if (s >= cap) s = s - cap;
    return s;
  endfunction

  logic [rbd_pkg::DATA_W-1:0] mem [DEPTH];

  logic [rbd_pkg::CMD_W-1:0]  cmd_r;
  logic [rbd_pkg::DATA_W-1:0] data_r;
  logic [rbd_pkg::POS_W-1:0]  pos_r;

  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic [SW-1:0] scan_slot_r, scan_slot_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0] cmp_idx_r;

  logic [rbd_pkg::DATA_W-1:0] rdata_r;
  logic [rbd_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [rbd_pkg::DATA_W-1:0] dout_r, dout_nxt;
  logic [rbd_pkg::POS_W-1:0]  fpos_r, fpos_nxt;

  logic          wr_en, rd_en;
  logic [SW-1:0] wr_slot, rd_slot;

  logic [CW:0]   cap6;
  logic [SW-1:0] head_prev, head_next, tail_prev, tail_next, pos_slot, scan_next;
  logic          full, empty, pos_bad, scan_more;

  // Ring pointer arithmetic
  always_comb begin
    cap6      = {1'b0, cap_r};
    head_prev = (head_r == '0) ? SW'(cap_r - 1'b1) : SW'(head_r - 1'b1);
    tail_prev = (tail_r == '0) ? SW'(cap_r - 1'b1) : SW'(tail_r - 1'b1);
    head_next = SW'(wrap_add((CW+1)'(head_r), (CW+1)'(1), cap6));
    tail_next = SW'(wrap_add((CW+1)'(tail_r), (CW+1)'(1), cap6));
    pos_slot  = SW'(wrap_add((CW+1)'(head_r), (CW+1)'(pos_r), cap6));
    scan_next = SW'(wrap_add((CW+1)'(scan_slot_r), (CW+1)'(1), cap6));
    full      = (count_r >= cap_r);
    empty     = (count_r == '0);
    pos_bad   = ((CW+1)'(pos_r) >= (CW+1)'(count_r));
    scan_more = (scan_idx_r < count_r);
  end

  // Execute the latched request and step the find scan
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    scan_slot_nxt = scan_slot_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = ctl.scan && scan_more;
    status_nxt    = status_r;
    dout_nxt      = dout_r;
    fpos_nxt      = fpos_r;
    wr_en         = 1'b0;
    wr_slot       = head_prev;
    rd_en         = 1'b0;
    rd_slot       = scan_slot_r;
    sts.need_rd   = 1'b0;
    sts.need_scan = 1'b0;
    sts.scan_hit  = cmp_vld_r && (rdata_r == data_r);
    sts.scan_last = cmp_vld_r && (cmp_idx_r == CW'(count_r - 1'b1));

    if (ctl.exec) begin
      status_nxt  = rbd_pkg::ST_OK;
      dout_nxt    = '0;
      fpos_nxt    = '0;
      cmp_vld_nxt = 1'b0;
      unique case (cmd_r)
        rbd_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_nxt = rbd_pkg::ST_FULL;
          end else begin
            head_nxt  = head_prev;
            wr_en     = 1'b1;
            wr_slot   = head_prev;
            count_nxt = CW'(count_r + 1'b1);
          end
        end
        rbd_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = rbd_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_slot   = tail_r;
            tail_nxt  = tail_next;
            count_nxt = CW'(count_r + 1'b1);
          end
        end
        rbd_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_nxt = rbd_pkg::ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            rd_slot     = head_r;
            head_nxt    = head_next;
            count_nxt   = CW'(count_r - 1'b1);
            sts.need_rd = 1'b1;
          end
        end
        rbd_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_nxt = rbd_pkg::ST_EMPTY;
          end else begin
            tail_nxt    = tail_prev;
            rd_en       = 1'b1;
            rd_slot     = tail_prev;
            count_nxt   = CW'(count_r - 1'b1);
            sts.need_rd = 1'b1;
          end
        end
        rbd_pkg::CMD_READ_AT: begin
          if (pos_bad) begin
            status_nxt = rbd_pkg::ST_RANGE;
          end else begin
            rd_en       = 1'b1;
            rd_slot     = pos_slot;
            sts.need_rd = 1'b1;
          end
        end
        rbd_pkg::CMD_FIND: begin
          status_nxt    = rbd_pkg::ST_NOT_FOUND;
          scan_slot_nxt = head_r;
          scan_idx_nxt  = '0;
          sts.need_scan = !empty;
        end
        default: begin
        end
      endcase
    end

    // Capture popped or read data
    if (ctl.capture) dout_nxt = rdata_r;

    // Issue one store read a cycle and compare the previous one
    if (ctl.scan) begin
      rd_en = 1'b1;
      if (scan_more) begin
        scan_slot_nxt = scan_next;
        scan_idx_nxt  = CW'(scan_idx_r + 1'b1);
      end
      if (sts.scan_hit) begin
        status_nxt = rbd_pkg::ST_OK;
        fpos_nxt   = rbd_pkg::POS_W'(cmp_idx_r);
      end
    end

    // Capacity write: clamp and empty the deque
    cap_nxt = cap_r;
    if (cfg_we) begin
      priority if (cfg_data == '0) cap_nxt = CW'(1);
      else if (cfg_data > CAP_MAX_V) cap_nxt = CAP_MAX_V;
      else                          cap_nxt = cfg_data;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  // Ring store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(wr_slot)] <= data_r;
    if (rd_en) rdata_r <= mem[AW'(rd_slot)];
  end

  // Hold pointers, count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      cap_r     <= CAP_RST_V;
      cmp_vld_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      cap_r     <= cap_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Latch the request, scan position and work result
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r  <= in_cmd;
      data_r <= in_data_in;
      pos_r  <= in_position;
    end
    scan_slot_r <= scan_slot_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= scan_idx_r;
    status_r    <= status_nxt;
    dout_r      <= dout_nxt;
    fpos_r      <= fpos_nxt;
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_status         <= status_r;
      out_data_out       <= dout_r;
      out_found_position <= fpos_r;
      out_occupancy      <= count_r;
    end
  end

endmodule

`default_nettype wire

>>> design/rbd_checker.sv
// Port-level checks for the ring buffer deque, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rbd_checker (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire                        in_ready,
  input  wire                        out_valid,
  input  wire                        out_ready,
  input  wire [rbd_pkg::STAT_W-1:0]  out_status,
  input  wire [rbd_pkg::DATA_W-1:0]  out_data_out,
  input  wire [rbd_pkg::POS_W-1:0]   out_found_position
);

  // Stalled result keeps its data
  `AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_out))

  // Status is always a defined code
  `AST_IMP(a_status_code, out_valid, out_status <= rbd_pkg::ST_NOT_FOUND)

  // Failed request returns zero data
  `AST_IMP(a_err_zero, out_valid && out_status != rbd_pkg::ST_OK, out_data_out == '0)

  // Missed find reports position zero
  `AST_IMP(a_miss_pos, out_valid && out_status == rbd_pkg::ST_NOT_FOUND, out_found_position == '0)

  // One request in flight at a time
  `AST_NXT(a_one_req, in_valid && in_ready, !in_ready)

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

`default_nettype wire
